// File: hw/rtl/brf_pkg.sv
// ============================================================================
// brf_pkg
// Shared opcodes, status codes and result types for the byte ring FIFO.
// ============================================================================
package brf_pkg;

  localparam int OP_W   = 3;
  localparam int STAT_W = 3;
  localparam int BYTE_W = 8;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE    = 3'd0,
    OP_READ     = 3'd1,
    OP_PEEK     = 3'd2,
    OP_COMMIT   = 3'd3,
    OP_ROLLBACK = 3'd4
  } brf_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NODATA   = 3'd2,
    ST_NOPEEK   = 3'd3,
    ST_PEEKOPEN = 3'd4
  } brf_stat_t;

  // per-item result flags, parameter free
  typedef struct packed {
    logic      done;
    brf_stat_t status;
    logic      rd_sel;   // read_data comes from the store
  } brf_res_t;

endpackage

// File: hw/rtl/byte_ring_fifo_peek_commit_core.sv
// ============================================================================
// byte_ring_fifo_peek_commit_core
// Byte ring FIFO with tentative peek reads and commit / rollback.
// ============================================================================
// Each input item carries one opcode (write, read, peek, commit, rollback)
// and gives exactly one result item in the next cycle: the byte for a read
// or peek (zero otherwise), done flag, status, and the fill count with full
// and empty flags after the item. The block takes one item per clock cycle
// when the result side keeps up; the byte store's registered read port and
// the result register are loaded in the same cycle. While a result is held
// by out_stall, in_stall is raised. The store needs no clearing after
// reset: reads and peeks never reach past the fill count. A read while a
// peek is open is rejected with the peek-open status; writes are allowed
// and extend the peek bound.
// ============================================================================
module byte_ring_fifo_peek_commit_core
  import brf_pkg::*;
#(
  parameter int DEPTH = 256,
  localparam int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  input  logic [BYTE_W-1:0] in_write_data,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_read_data,
  output logic              out_done_res,
  output logic [STAT_W-1:0] out_status,
  output logic [CNT_W-1:0]  out_fill_count,
  output logic              out_is_full,
  output logic              out_is_empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic              accept;
  logic              ram_we;
  logic              ram_re;
  logic [PTR_W-1:0]  ram_waddr;
  logic [PTR_W-1:0]  ram_raddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  brf_res_t          res;
  logic [CNT_W-1:0]  cnt_nxt;

  // result register
  logic              out_valid_r, out_valid_nxt;
  brf_res_t          res_r;
  logic [CNT_W-1:0]  fill_r;
  logic              full_r;
  logic              empty_r;

  // a held result blocks the input; a draining one does not
  assign in_stall = out_valid_r & out_stall;
  assign accept   = in_valid & ~in_stall;

  brf_ctrl #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .opcode     (in_opcode),
    .write_data (in_write_data),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .res        (res),
    .cnt_nxt    (cnt_nxt)
  );

  // read data register only moves on an accepted read/peek, so it stays
  // stable while the matching result is stalled
  brf_ram #(
    .DEPTH (DEPTH),
    .PTR_W (PTR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_r   <= res;
      fill_r  <= cnt_nxt;
      full_r  <= (cnt_nxt == FULL_CNT);
      empty_r <= (cnt_nxt == '0);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = res_r.rd_sel ? ram_rdata : '0;
  assign out_done_res   = res_r.done;
  assign out_status     = res_r.status;
  assign out_fill_count = fill_r;
  assign out_is_full    = full_r;
  assign out_is_empty   = empty_r;

endmodule

// File: hw/rtl/brf_ram.sv
// ============================================================================
// brf_ram
// Byte store: one write port, one read port, registered read data.
// ============================================================================
module brf_ram
  import brf_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int PTR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [PTR_W-1:0]  waddr,
  input  logic [BYTE_W-1:0] wdata,
  input  logic              re,
  input  logic [PTR_W-1:0]  raddr,
  output logic [BYTE_W-1:0] rdata
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read register holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/brf_ctrl.sv
// ============================================================================
// brf_ctrl
// Pointer, count and peek bookkeeping; issues store accesses per item.
// ============================================================================
module brf_ctrl
  import brf_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int PTR_W = 8,
  parameter int CNT_W = 9
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [OP_W-1:0]   opcode,
  input  logic [BYTE_W-1:0] write_data,
  output logic              ram_we,
  output logic [PTR_W-1:0]  ram_waddr,
  output logic [BYTE_W-1:0] ram_wdata,
  output logic              ram_re,
  output logic [PTR_W-1:0]  ram_raddr,
  output brf_res_t          res,
  output logic [CNT_W-1:0]  cnt_nxt
);

  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0] pk_ptr_r, pk_ptr_nxt;
  logic [CNT_W-1:0] pk_cnt_r, pk_cnt_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [PTR_W-1:0] pk_addr;
  logic             pk_open;

  assign pk_open = (pk_cnt_r != '0);
  // first peek starts at the read pointer
  assign pk_addr = pk_open ? pk_ptr_r : rd_ptr_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    pk_ptr_nxt = pk_ptr_r;
    pk_cnt_nxt = pk_cnt_r;
    cnt_nxt    = cnt_r;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_waddr  = wr_ptr_r;
    ram_wdata  = write_data;
    ram_raddr  = rd_ptr_r;
    res.done   = 1'b0;
    res.status = ST_OK;
    res.rd_sel = 1'b0;
    unique case (opcode)
      OP_WRITE: begin
        if (cnt_r == FULL_CNT) begin
          res.status = ST_FULL;
        end else begin
          ram_we     = accept;
          wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
          cnt_nxt    = cnt_r + 1'b1;
          res.done   = 1'b1;
        end
      end
      OP_READ: begin
        if (pk_open) begin
          res.status = ST_PEEKOPEN;
        end else if (cnt_r == '0) begin
          res.status = ST_NODATA;
        end else begin
          ram_re     = accept;
          ram_raddr  = rd_ptr_r;
          rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
          cnt_nxt    = cnt_r - 1'b1;
          res.done   = 1'b1;
          res.rd_sel = 1'b1;
        end
      end
      OP_PEEK: begin
        if (pk_cnt_r >= cnt_r) begin
          res.status = ST_NODATA;
        end else begin
          ram_re     = accept;
          ram_raddr  = pk_addr;
          pk_ptr_nxt = (pk_addr == LAST_SLOT) ? '0 : pk_addr + 1'b1;
          pk_cnt_nxt = pk_cnt_r + 1'b1;
          res.done   = 1'b1;
          res.rd_sel = 1'b1;
        end
      end
      OP_COMMIT: begin
        if (!pk_open) begin
          res.status = ST_NOPEEK;
        end else begin
          rd_ptr_nxt = pk_ptr_r;
          cnt_nxt    = cnt_r - pk_cnt_r;
          pk_cnt_nxt = '0;
          res.done   = 1'b1;
        end
      end
      OP_ROLLBACK: begin
        if (!pk_open) begin
          res.status = ST_NOPEEK;
        end else begin
          pk_cnt_nxt = '0;
          res.done   = 1'b1;
        end
      end
      default: begin
        // unused opcodes: no effect, status ok
        res.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      pk_ptr_r <= '0;
      pk_cnt_r <= '0;
      cnt_r    <= '0;
    end else if (accept) begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      pk_ptr_r <= pk_ptr_nxt;
      pk_cnt_r <= pk_cnt_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// File: hw/rtl/brf_chk.sv
// ============================================================================
// brf_chk
// Port-level checks on the result channel of the byte ring FIFO.
// ============================================================================
module brf_chk
  import brf_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_read_data,
  input logic              out_done_res,
  input logic [STAT_W-1:0] out_status,
  input logic [CNT_W-1:0]  out_fill_count,
  input logic              out_is_full,
  input logic              out_is_empty
);

  // no result survives reset
  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_done_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> out_status == ST_OK)
    else $error("done with non-ok status");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_done_res |-> out_read_data == '0)
    else $error("failed item returned data");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_full && out_is_empty))
    else $error("full and empty together");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fill_count))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo_peek_commit_core brf_chk #(
  .DEPTH (DEPTH),
  .CNT_W (CNT_W)
) u_brf_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_read_data  (out_read_data),
  .out_done_res   (out_done_res),
  .out_status     (out_status),
  .out_fill_count (out_fill_count),
  .out_is_full    (out_is_full),
  .out_is_empty   (out_is_empty)
);

// File: bench/tb_byte_ring_fifo_peek_commit_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_byte_ring_fifo_peek_commit_core
// Self-checking bench for the byte ring FIFO with peek, commit and rollback.
// A short table of directed items is followed by random, sequence-shaped
// traffic: write and read bursts, peek runs mostly closed by commit or
// rollback, a fill to full and drains to empty, plus raw opcode noise.
// Each result is checked against its typed-in row or a cycle-free FIFO model.
// ----------------------------------------------------------------------------
module tb_byte_ring_fifo_peek_commit_core;
  import brf_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int RST_CYCLES = 9;
  localparam int DEPTH      = 256;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int N_ITEMS    = 1250;
  localparam int HOLD_CYC   = 300;   // long receiver hold-off
  localparam int WD_LIMIT   = 3000;  // cycles without any handshake
  localparam int SHOW_MAX   = 10;
  localparam int N_DIR      = 23;

  // opcodes the block must ignore
  localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
  localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
  localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

  // one result item, field for field
  typedef struct packed {
    logic [BYTE_W-1:0] rdata;
    logic              done;
    brf_stat_t         stat;
    logic [CNT_W-1:0]  fill;
    logic              full;
    logic              empty;
  } fifo_res_t;

  // one row of the directed table; want is used only when fixed is set
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic              fixed;
    fifo_res_t         want;
  } dir_row_t;

  localparam fifo_res_t NO_WANT = '{8'h00, 1'b0, ST_OK, 9'd0, 1'b0, 1'b0};

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic              in_valid;
  logic              in_stall;
  logic [OP_W-1:0]   in_opcode;
  logic [BYTE_W-1:0] in_write_data;
  logic              out_valid;
  logic              out_stall;
  logic [BYTE_W-1:0] out_read_data;
  logic              out_done_res;
  logic [STAT_W-1:0] out_status;
  logic [CNT_W-1:0]  out_fill_count;
  logic              out_is_full;
  logic              out_is_empty;

  always #(CLK_PERIOD / 2) clk = ~clk;

  byte_ring_fifo_peek_commit_core #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data),
    .out_done_res  (out_done_res),
    .out_status    (out_status),
    .out_fill_count(out_fill_count),
    .out_is_full   (out_is_full),
    .out_is_empty  (out_is_empty)
  );

  // --------------------------------------------------------------------------
  // FIFO model: store, pointers, peek cursor and counts.
  // Reads and peeks are bounded by the count, so unwritten slots are never
  // touched.
  // --------------------------------------------------------------------------
  logic [BYTE_W-1:0] fifo_mem [DEPTH];
  int wr_ptr, rd_ptr, pk_ptr, pk_cnt, fill;

  function automatic int ring_next(int p);
    return (p == DEPTH - 1) ? 0 : p + 1;
  endfunction

  function automatic logic [BYTE_W-1:0] rnd_byte();
    return BYTE_W'($urandom_range(255));
  endfunction

  // applies one opcode to the model and returns the result it causes
  function automatic fifo_res_t apply_fifo_op(logic [OP_W-1:0] op,
                                              logic [BYTE_W-1:0] wd);
    fifo_res_t r;
    r = NO_WANT;
    case (op)
      OP_WRITE: begin
        if (fill >= DEPTH) begin
          r.stat = ST_FULL;
        end else begin
          fifo_mem[wr_ptr] = wd;
          wr_ptr = ring_next(wr_ptr);
          fill++;
          r.done = 1'b1;
        end
      end
      OP_READ: begin
        if (pk_cnt != 0) begin
          r.stat = ST_PEEKOPEN;
        end else if (fill == 0) begin
          r.stat = ST_NODATA;
        end else begin
          r.rdata = fifo_mem[rd_ptr];
          rd_ptr = ring_next(rd_ptr);
          fill--;
          r.done = 1'b1;
        end
      end
      OP_PEEK: begin
        if (pk_cnt >= fill) begin
          r.stat = ST_NODATA;
        end else begin
          // first peek of a run starts at the read pointer
          if (pk_cnt == 0) pk_ptr = rd_ptr;
          r.rdata = fifo_mem[pk_ptr];
          pk_ptr = ring_next(pk_ptr);
          pk_cnt++;
          r.done = 1'b1;
        end
      end
      OP_COMMIT: begin
        if (pk_cnt == 0) begin
          r.stat = ST_NOPEEK;
        end else begin
          rd_ptr = pk_ptr;
          fill -= pk_cnt;
          pk_cnt = 0;
          r.done = 1'b1;
        end
      end
      OP_ROLLBACK: begin
        if (pk_cnt == 0) begin
          r.stat = ST_NOPEEK;
        end else begin
          pk_cnt = 0;
          r.done = 1'b1;
        end
      end
      default: ;  // unused opcodes change nothing
    endcase
    r.fill  = fill[CNT_W-1:0];
    r.full  = (fill == DEPTH);
    r.empty = (fill == 0);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input handshake, check on result handshake.
  // Both run in one block so their order is fixed: check first, then predict.
  // --------------------------------------------------------------------------
  fifo_res_t res_due_q[$];
  logic      cur_fixed;   // offered item carries a typed-in expectation
  fifo_res_t cur_want;
  int        n_err;

  initial begin
    wr_ptr = 0;
    rd_ptr = 0;
    pk_ptr = 0;
    pk_cnt = 0;
    fill   = 0;
    n_err  = 0;
  end

  always @(posedge clk) begin
    fifo_res_t got;
    fifo_res_t want;
    fifo_res_t pred;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.rdata = out_read_data;
        got.done  = out_done_res;
        got.stat  = brf_stat_t'(out_status);
        got.fill  = out_fill_count;
        got.full  = out_is_full;
        got.empty = out_is_empty;
        if (res_due_q.size() == 0) begin
          n_err++;
          if (n_err <= SHOW_MAX)
            $display("%0t: result with nothing expected: rd=%h done=%b st=%0d fill=%0d",
                     $realtime, got.rdata, got.done, got.stat, got.fill);
        end else begin
          want = res_due_q.pop_front();
          if (got.rdata !== want.rdata || got.done !== want.done ||
              got.stat !== want.stat || got.fill !== want.fill ||
              got.full !== want.full || got.empty !== want.empty) begin
            n_err++;
            if (n_err <= SHOW_MAX) begin
              $write("%0t: mismatch exp rd=%h done=%b st=%0d fill=%0d full=%b empty=%b",
                     $realtime, want.rdata, want.done, want.stat, want.fill,
                     want.full, want.empty);
              $display(" / got rd=%h done=%b st=%0d fill=%0d full=%b empty=%b",
                       got.rdata, got.done, got.stat, got.fill, got.full,
                       got.empty);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        // model always advances; a typed-in row overrides its prediction
        pred = apply_fifo_op(in_opcode, in_write_data);
        res_due_q.push_back(cur_fixed ? cur_want : pred);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any handshake ends the run
  // --------------------------------------------------------------------------
  int idle_cyc = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WD_LIMIT) begin
      $display("tb_byte_ring_fifo_peek_commit_core NOT OK");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stalls, one long hold-off on request, none when calm
  // --------------------------------------------------------------------------
  bit hold_req = 1'b0;
  bit calm     = 1'b0;

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 6);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  int n_sent = 0;

  // Offers one item at a falling edge, holds it until accepted, and returns
  // at the next falling edge so the model already reflects the item.
  task automatic send_op(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] wd,
                         input logic fixed = 1'b0, input fifo_res_t want = NO_WANT);
    int gap;
    gap = (!calm && $urandom_range(99) < 6) ? 1 : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_write_data <= wd;
    cur_fixed = fixed;
    cur_want  = want;
    do @(posedge clk); while (in_stall);
    n_sent++;
    @(negedge clk);
  endtask

  // sender pauses until the block has handed back every result
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (res_due_q.size() == 0);
    @(negedge clk);
  endtask

  dir_row_t dir_tab [N_DIR];

  initial begin
    int n;
    int k;
    bit hold_done;
    bit pause_done;
    hold_done  = 1'b0;
    pause_done = 1'b0;

    // Directed items. Rows with fixed = 1 carry their result; the rest are
    // left to the model.
    dir_tab = '{
      // empty FIFO: read, peek, commit, rollback all refused
      '{OP_READ,       8'h00, 1'b1, '{8'h00, 1'b0, ST_NODATA,   9'd0, 1'b0, 1'b1}},
      '{OP_PEEK,       8'h00, 1'b1, '{8'h00, 1'b0, ST_NODATA,   9'd0, 1'b0, 1'b1}},
      '{OP_COMMIT,     8'h5A, 1'b1, '{8'h00, 1'b0, ST_NOPEEK,   9'd0, 1'b0, 1'b1}},
      '{OP_ROLLBACK,   8'hA5, 1'b1, '{8'h00, 1'b0, ST_NOPEEK,   9'd0, 1'b0, 1'b1}},
      // unused opcodes do nothing
      '{OP_UNUSED_LO,  8'h00, 1'b1, '{8'h00, 1'b0, ST_OK,       9'd0, 1'b0, 1'b1}},
      '{OP_UNUSED_HI,  8'hFF, 1'b1, '{8'h00, 1'b0, ST_OK,       9'd0, 1'b0, 1'b1}},
      // data extremes
      '{OP_WRITE,      8'h00, 1'b1, '{8'h00, 1'b1, ST_OK,       9'd1, 1'b0, 1'b0}},
      '{OP_WRITE,      8'hFF, 1'b1, '{8'h00, 1'b1, ST_OK,       9'd2, 1'b0, 1'b0}},
      // open a peek, then a read must be refused
      '{OP_PEEK,       8'h00, 1'b1, '{8'h00, 1'b1, ST_OK,       9'd2, 1'b0, 1'b0}},
      '{OP_READ,       8'h00, 1'b1, '{8'h00, 1'b0, ST_PEEKOPEN, 9'd2, 1'b0, 1'b0}},
      // write during a peek extends the peek bound
      '{OP_WRITE,      8'hA5, 1'b0, NO_WANT},
      '{OP_PEEK,       8'h00, 1'b0, NO_WANT},
      '{OP_PEEK,       8'h00, 1'b0, NO_WANT},
      // everything peeked
      '{OP_PEEK,       8'h00, 1'b0, NO_WANT},
      '{OP_ROLLBACK,   8'h00, 1'b0, NO_WANT},
      '{OP_PEEK,       8'h00, 1'b0, NO_WANT},
      '{OP_COMMIT,     8'h00, 1'b0, NO_WANT},
      '{OP_READ,       8'h00, 1'b0, NO_WANT},
      '{OP_READ,       8'h00, 1'b0, NO_WANT},
      '{OP_READ,       8'h00, 1'b0, NO_WANT},
      '{OP_UNUSED_MID, 8'h5A, 1'b0, NO_WANT},
      '{OP_WRITE,      8'h80, 1'b0, NO_WANT},
      '{OP_WRITE,      8'h01, 1'b0, NO_WANT}
    };

    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = OP_WRITE;
    in_write_data = '0;
    cur_fixed     = 1'b0;
    cur_want      = NO_WANT;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send_op(dir_tab[i].op, dir_tab[i].data, dir_tab[i].fixed, dir_tab[i].want);

    // Fill to full, try two more writes, then peek past the whole content
    // (pointer wrap on the cursor) and roll back.
    while (fill < DEPTH) send_op(OP_WRITE, rnd_byte());
    repeat (2) send_op(OP_WRITE, rnd_byte());
    repeat (DEPTH + 2) send_op(OP_PEEK, rnd_byte());
    send_op(OP_ROLLBACK, rnd_byte());

    while (n_sent < N_ITEMS) begin
      // one sender pause until all results are back
      if (n_sent >= 550 && !pause_done) begin
        drain_results();
        pause_done = 1'b1;
      end
      // one long receiver hold-off while items keep coming
      if (n_sent >= 700 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      calm = (n_sent >= 850 && n_sent < 1050);

      case ($urandom_range(9))
        0, 1, 2: begin
          repeat ($urandom_range(24, 1)) send_op(OP_WRITE, rnd_byte());
        end
        3, 4: begin
          repeat ($urandom_range(24, 1)) send_op(OP_READ, rnd_byte());
        end
        5, 6, 7: begin
          // peek run, now and then broken by a write or a read (refused while a peek is open)
          n = $urandom_range((fill < 30) ? fill + 2 : 32, 1);
          repeat (n) begin
            k = $urandom_range(99);
            if (k < 8)       send_op(OP_WRITE, rnd_byte());
            else if (k < 12) send_op(OP_READ, rnd_byte());
            else             send_op(OP_PEEK, rnd_byte());
          end
          k = $urandom_range(9);
          if (k < 6)      send_op(OP_COMMIT, rnd_byte());
          else if (k < 9) send_op(OP_ROLLBACK, rnd_byte());
          // else the peek stays open
        end
        8: begin
          repeat ($urandom_range(8, 1))
            send_op(OP_W'($urandom_range(7)), rnd_byte());
        end
        default: begin
          // drain to empty and read past it
          if (pk_cnt != 0) send_op(OP_COMMIT, rnd_byte());
          while (fill > 0) send_op(OP_READ, rnd_byte());
          repeat (2) send_op(OP_READ, rnd_byte());
        end
      endcase
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    wait (res_due_q.size() == 0);
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (n_err == 0 && res_due_q.size() == 0) begin
      $display("tb_byte_ring_fifo_peek_commit_core OK");
    end else begin
      $display("tb_byte_ring_fifo_peek_commit_core NOT OK");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/brf_pkg.sv
hw/rtl/brf_ram.sv
hw/rtl/brf_ctrl.sv
hw/rtl/byte_ring_fifo_peek_commit_core.sv
hw/rtl/brf_chk.sv
bench/tb_byte_ring_fifo_peek_commit_core.sv
